@@ hw/rtl/dsps_pkg.sv @@
// ----------------------------------------------------------------------------
// dsps_pkg
// Shared types and constants for the dual serial port shifter.
// ----------------------------------------------------------------------------
package dsps_pkg;

	// Defaults for the top level parameters
	localparam int NUM_PORTS_DEFAULT  = 2;
	localparam int FRAME_BITS_DEFAULT = 8;

	// Width of the per-port line fields in the payload
	localparam int PORT_LINES = 2;

	localparam logic [15:0] BIT_PERIOD_RESET = 16'h0088;

	// Operation codes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Register offsets
	localparam logic [3:0] OFF_DATA   = 4'h0;
	localparam logic [3:0] OFF_STATUS = 4'h4;
	localparam logic [3:0] OFF_MODE   = 4'h8;
	localparam logic [3:0] OFF_CTRL   = 4'hA;
	localparam logic [3:0] OFF_BAUD   = 4'hE;

	// Control register bits
	localparam int CTRL_TX_EN_BIT = 0;
	localparam int CTRL_DTR_BIT   = 1;
	localparam int CTRL_SEL_BIT   = 13;
	localparam logic [15:0] CTRL_IRQ_ACK   = 16'h0010;
	localparam logic [15:0] CTRL_PORT_RST  = 16'h0040;
	localparam logic [15:0] CTRL_TX_IRQ_EN = 16'h0400;
	localparam logic [15:0] CTRL_RX_IRQ_EN = 16'h0800;
	localparam logic [15:0] CTRL_DSR_IRQ_EN = 16'h1000;

	// Bit index meaning "start bit next" (tx) or "hunting for start edge" (rx)
	localparam logic [3:0] IDX_HUNT = 4'hF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  address;
		logic [15:0] write_data;
		logic [1:0]  rxd_lines;
		logic [1:0]  dsr_lines;
	} dsps_in_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [1:0]  txd_lines;
		logic [1:0]  dtr_lines;
		logic [1:0]  select_lines;
		logic        irq;
	} dsps_out_t;

	// What one lane reports to the merge stage
	typedef struct packed {
		logic [15:0] rd;
		logic        txd;
		logic        dtr;
		logic        sel;
		logic        irq_set;
		logic        irq_clr;
	} dsps_lane_out_t;

endpackage

@@ hw/rtl/dsps_lane.sv @@
// ----------------------------------------------------------------------------
// dsps_lane
// One serial port: bus registers, bit divider, tx and rx shifters.
// ----------------------------------------------------------------------------
module dsps_lane #(
	parameter int FRAME_BITS = dsps_pkg::FRAME_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  dsps_pkg::dsps_in_t     item,
	input  logic                   hit,
	input  logic                   rxd,
	input  logic                   dsr,
	input  logic [15:0]            per,
	output dsps_pkg::dsps_lane_out_t result
);

	localparam logic [3:0] FRAME_IDX = 4'(FRAME_BITS);

	typedef struct packed {
		logic [7:0] rx_shift;
		logic [7:0] tx_shift;
		logic       rx_avail;
		logic       rx_armed;
		logic       tx_busy;
		logic [3:0] rx_idx;
		logic [3:0] tx_idx;
		logic       last_rxd;
		logic       last_dsr;
	} port_state_t;

	typedef struct packed {
		port_state_t st;
		logic        txd;
		logic        irq;
	} bit_ev_t;

	port_state_t st_q, st_n;
	logic [15:0] ctl_q, ctl_n;
	logic [15:0] mode_q, mode_n;
	logic [15:0] baud_q, baud_n;
	logic [15:0] div_q, div_n;
	bit_ev_t     ev1, ev2;
	logic        two_ev;
	logic [3:0]  offset;
	logic [15:0] wv;

	// One bit period of the port
	function automatic bit_ev_t bit_event(port_state_t s, logic [15:0] ctl,
			logic rx, logic ds);
		bit_ev_t    e;
		logic [3:0] nidx;
		e     = '0;
		e.st  = s;
		e.txd = 1'b1;
		nidx  = '0;
		if (s.tx_busy) begin
			if (s.tx_idx == dsps_pkg::IDX_HUNT) begin
				e.txd       = 1'b0;
				e.st.tx_idx = '0;
			end else begin
				e.txd       = s.tx_shift[s.tx_idx[2:0]];
				nidx        = s.tx_idx + 4'd1;
				e.st.tx_idx = nidx;
				if (nidx >= FRAME_IDX) begin
					e.st.tx_busy = 1'b0;
					if ((ctl & dsps_pkg::CTRL_TX_IRQ_EN) != '0) e.irq = 1'b1;
				end
			end
		end
		if (s.rx_armed) begin
			if (s.rx_idx == dsps_pkg::IDX_HUNT) begin
				if (!rx && s.last_rxd) e.st.rx_idx = '0;
			end else begin
				e.st.rx_shift[s.rx_idx[2:0]] = s.rx_shift[s.rx_idx[2:0]] | rx;
				nidx        = s.rx_idx + 4'd1;
				e.st.rx_idx = nidx;
				if (nidx >= FRAME_IDX) begin
					e.st.rx_armed = 1'b0;
					e.st.rx_avail = 1'b1;
					if ((ctl & dsps_pkg::CTRL_RX_IRQ_EN) != '0) e.irq = 1'b1;
				end
			end
		end
		if (ds && !s.last_dsr && ((ctl & dsps_pkg::CTRL_DSR_IRQ_EN) != '0)) e.irq = 1'b1;
		e.st.last_dsr = ds;
		e.st.last_rxd = rx;
		return e;
	endfunction

	assign offset = item.address[3:0];

	// Second bit period in one tick only from a zero divider at period one
	assign ev1    = bit_event(st_q, ctl_q, rxd, dsr);
	assign ev2    = bit_event(ev1.st, ctl_q, rxd, dsr);
	assign two_ev = (div_q == '0) && (per == 16'd1);

	always_comb begin
		st_n   = st_q;
		ctl_n  = ctl_q;
		mode_n = mode_q;
		baud_n = baud_q;
		div_n  = div_q;
		wv     = item.write_data;
		result = '0;
		result.txd = 1'b1;
		unique case (item.operation)
			dsps_pkg::OP_READ: begin
				if (hit) begin
					unique case (offset)
						dsps_pkg::OFF_DATA: begin
							result.rd     = {8'h00, st_q.rx_shift};
							st_n.rx_avail = 1'b0;
							if (!st_q.rx_armed) begin
								st_n.rx_shift = '0;
								st_n.rx_armed = 1'b1;
								st_n.rx_idx   = dsps_pkg::IDX_HUNT;
							end
						end
						dsps_pkg::OFF_STATUS: begin
							result.rd[1] = st_q.rx_avail;
							result.rd[0] = ctl_q[dsps_pkg::CTRL_TX_EN_BIT] && !st_q.rx_avail;
						end
						dsps_pkg::OFF_MODE: result.rd = mode_q;
						dsps_pkg::OFF_CTRL: result.rd = ctl_q;
						dsps_pkg::OFF_BAUD: result.rd = baud_q;
						default: result.rd = '0;
					endcase
				end
			end
			dsps_pkg::OP_WRITE: begin
				if (hit) begin
					unique case (offset)
						dsps_pkg::OFF_DATA: begin
							if (ctl_q[dsps_pkg::CTRL_TX_EN_BIT]) begin
								st_n.tx_shift = item.write_data[7:0];
								if (!st_q.tx_busy) begin
									st_n.tx_idx  = dsps_pkg::IDX_HUNT;
									st_n.tx_busy = 1'b1;
								end
							end
						end
						dsps_pkg::OFF_MODE: mode_n = item.write_data;
						dsps_pkg::OFF_CTRL: begin
							if ((wv & dsps_pkg::CTRL_IRQ_ACK) != '0) begin
								wv             = wv & ~dsps_pkg::CTRL_IRQ_ACK;
								result.irq_clr = 1'b1;
							end
							if ((wv & dsps_pkg::CTRL_PORT_RST) != '0) begin
								result.irq_clr = 1'b1;
								wv             = '0;
								st_n           = '0;
								mode_n         = '0;
								baud_n         = '0;
								div_n          = '0;
							end
							ctl_n = wv;
						end
						dsps_pkg::OFF_BAUD: baud_n = item.write_data;
						default: ;
					endcase
				end
			end
			dsps_pkg::OP_TICK: begin
				if (div_q == '0) begin
					if (two_ev) begin
						st_n           = ev2.st;
						result.txd     = ev2.txd;
						result.irq_set = ev1.irq | ev2.irq;
						div_n          = 16'd1;
					end else begin
						st_n           = ev1.st;
						result.txd     = ev1.txd;
						result.irq_set = ev1.irq;
						div_n          = per - 16'd1;
					end
				end else if (div_q == 16'd1) begin
					st_n           = ev1.st;
					result.txd     = ev1.txd;
					result.irq_set = ev1.irq;
					div_n          = per;
				end else begin
					div_n = div_q - 16'd1;
				end
			end
			default: ;
		endcase
		result.dtr = ctl_n[dsps_pkg::CTRL_DTR_BIT];
		result.sel = ctl_n[dsps_pkg::CTRL_SEL_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			ctl_q  <= '0;
			mode_q <= '0;
			baud_q <= '0;
			div_q  <= '0;
		end else if (advance) begin
			st_q   <= st_n;
			ctl_q  <= ctl_n;
			mode_q <= mode_n;
			baud_q <= baud_n;
			div_q  <= div_n;
		end
	end

	// A busy transmitter is either before its start bit or inside the frame
	a_tx_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.tx_busy |-> (st_q.tx_idx == dsps_pkg::IDX_HUNT || st_q.tx_idx < FRAME_IDX))
		else $error("tx bit index out of frame");

	a_rx_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.rx_armed |-> (st_q.rx_idx == dsps_pkg::IDX_HUNT || st_q.rx_idx < FRAME_IDX))
		else $error("rx bit index out of frame");

endmodule

@@ hw/rtl/dsps_merge.sv @@
// ----------------------------------------------------------------------------
// dsps_merge
// Combines the lane results and holds the shared interrupt level.
// ----------------------------------------------------------------------------
module dsps_merge #(
	parameter int NUM_PORTS = dsps_pkg::NUM_PORTS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  dsps_pkg::dsps_lane_out_t lanes [NUM_PORTS],
	output dsps_pkg::dsps_out_t      result
);

	logic irq_q, irq_n;
	logic any_set, any_clr;

	always_comb begin
		result  = '0;
		any_set = 1'b0;
		any_clr = 1'b0;
		for (int q = 0; q < NUM_PORTS; q++) begin
			result.read_data       = result.read_data | lanes[q].rd;
			result.txd_lines[q]    = lanes[q].txd;
			result.dtr_lines[q]    = lanes[q].dtr;
			result.select_lines[q] = lanes[q].sel;
			any_set = any_set | lanes[q].irq_set;
			any_clr = any_clr | lanes[q].irq_clr;
		end
		priority if (any_clr) irq_n = 1'b0;
		else                  irq_n = irq_q | any_set;
		result.irq = irq_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q <= 1'b0;
		end else if (advance) begin
			irq_q <= irq_n;
		end
	end

endmodule

@@ hw/rtl/dsps_obuf.sv @@
// ----------------------------------------------------------------------------
// dsps_obuf
// Result register with a skid stage, so input and output stall apart.
// ----------------------------------------------------------------------------
module dsps_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dsps_pkg::dsps_out_t push_data,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output dsps_pkg::dsps_out_t out_data
);

	logic                out_valid_q, skid_valid_q;
	dsps_pkg::dsps_out_t out_data_q, skid_data_q;
	logic                pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= out_valid_q || push;
				skid_valid_q <= skid_valid_q || (push && out_valid_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end else if (push && (!out_valid_q || pop)) begin
			out_data_q <= push_data;
		end
		if (push && out_valid_q && !pop) begin
			skid_data_q <= push_data;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without a head entry");

	a_skid_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled while head was free");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("transaction pushed into a full buffer");

endmodule

@@ hw/rtl/dual_serial_port_shifter_unit.sv @@
// A result is registered in the head entry, or the skid entry if the head is stalled.
// Throughput: one transaction per cycle unless in_stall; lanes update on acceptance.
// Result buffer holds two: a stalled output takes one more transaction, then in_stall
// rises; it drops the cycle after the output moves again.
// Reset: async active low; all port state and irq clear, bit period loads 136.
// ----------------------------------------------------------------------------
// dual_serial_port_shifter_unit
// Two serial ports behind bus registers with a shared interrupt line.
// ----------------------------------------------------------------------------
module dual_serial_port_shifter_unit #(
	parameter int NUM_PORTS  = dsps_pkg::NUM_PORTS_DEFAULT,
	parameter int FRAME_BITS = dsps_pkg::FRAME_BITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	// input transaction channel
	input  logic                in_valid,
	output logic                in_stall,
	input  dsps_pkg::dsps_in_t  in_data,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output dsps_pkg::dsps_out_t out_data,
	// bit period register
	input  logic                cfg_write,
	input  logic [15:0]         cfg_data
);

	logic                     in_fire;
	logic                     buf_full;
	logic [15:0]              bit_period_q;
	logic [15:0]              per;
	dsps_pkg::dsps_lane_out_t lane_res [NUM_PORTS];
	dsps_pkg::dsps_out_t      merged;

	// Accept whenever the skid stage has room; stall is a register output.
	assign in_stall = buf_full;
	assign in_fire  = in_valid && !buf_full;

	// Bit period register; zero behaves as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= dsps_pkg::BIT_PERIOD_RESET;
		end else if (cfg_write) begin
			bit_period_q <= cfg_data;
		end
	end

	assign per = (bit_period_q == '0) ? 16'd1 : bit_period_q;

	// One lane per port. Each lane decodes the bus transaction against
	// its own registers (address bit 4 picks the lane; ignored with a
	// single port) and runs its own divider and shifters on ticks.
	for (genvar q = 0; q < NUM_PORTS; q++) begin : g_lane
		logic hit;

		assign hit = (NUM_PORTS == 1) || (in_data.address[4] == 1'(q));

		dsps_lane #(
			.FRAME_BITS (FRAME_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (in_fire),
			.item    (in_data),
			.hit     (hit),
			.rxd     (in_data.rxd_lines[q]),
			.dsr     (in_data.dsr_lines[q]),
			.per     (per),
			.result  (lane_res[q])
		);
	end

	// Merge: read data, line levels and the shared irq level.
	dsps_merge #(
		.NUM_PORTS (NUM_PORTS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (in_fire),
		.lanes   (lane_res),
		.result  (merged)
	);

	// Result register plus skid entry.
	dsps_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_data (merged),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
